@@ rtl/rleg_pkg.sv @@
// Shared types, constants and lookup functions for the RGB LED effect generator.
package rleg_pkg;

    localparam int PULSE_FRAMES_DEF = 4;
    localparam int PFL_W            = 3;   // holds pulse counts up to 7
    localparam int MODE_W           = 3;
    localparam int FRAME_W          = 16;
    localparam int LVL_W            = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;

    // mode codes; codes five to seven draw as loss
    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SPIN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CRAWL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WIN     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_JACKPOT = 3'd4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_FLOOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HOLD   = 2'd3;

    localparam logic [7:0]  BREATH_LO_RST  = 8'd4;
    localparam logic [7:0]  BREATH_HI_RST  = 8'd40;
    localparam logic [7:0]  SPIN_FLOOR_RST = 8'd12;
    localparam logic [15:0] WIN_HOLD_RST   = 16'd30;

    // shared multiplier
    localparam int MUL_A_W   = 16;
    localparam int MUL_B_W   = 25;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MOD_SHIFT = 22;  // reciprocal scale for frame reductions
    localparam int DIV_SHIFT = 24;  // reciprocal scale for level scaling
    localparam int MOD_Q_W   = 14;
    localparam int MOD_R_W   = 20;

    localparam int BREATH_PERIOD = 76;
    localparam int BREATH_HALF   = BREATH_PERIOD / 2;
    localparam int CRAWL_PERIOD  = 30;
    localparam int JACKPOT_STEPS = 6;

    localparam logic [MOD_R_W-1:0] BREATH_RECIP  = MOD_R_W'((2**MOD_SHIFT) / BREATH_PERIOD);
    localparam logic [MOD_R_W-1:0] CRAWL_RECIP   = MOD_R_W'((2**MOD_SHIFT) / CRAWL_PERIOD);
    localparam logic [MOD_R_W-1:0] JACKPOT_RECIP = MOD_R_W'((2**MOD_SHIFT) / JACKPOT_STEPS);

    localparam int NOTE_LEN0  = 4;
    localparam int NOTE_LEN1  = 4;
    localparam int NOTE_LEN2  = 6;
    localparam int NOTE_END0  = NOTE_LEN0;
    localparam int NOTE_END1  = NOTE_END0 + NOTE_LEN1;
    localparam int NOTE_END2  = NOTE_END1 + NOTE_LEN2;
    localparam logic [7:0] NOTE_PEAK0 = 8'd255;
    localparam logic [7:0] NOTE_PEAK1 = 8'd190;
    localparam logic [7:0] NOTE_PEAK2 = 8'd130;
    localparam logic [7:0] WIN_REST   = 8'd30;
    localparam logic [7:0] WIN_FULL   = 8'd255;

    localparam logic [MUL_B_W-1:0] RECIP_255   = MUL_B_W'((2**DIV_SHIFT + 254) / 255);
    localparam logic [MUL_B_W-1:0] RECIP_NOTE0 =
        MUL_B_W'((2**DIV_SHIFT + NOTE_LEN0 - 1) / NOTE_LEN0);
    localparam logic [MUL_B_W-1:0] RECIP_NOTE1 =
        MUL_B_W'((2**DIV_SHIFT + NOTE_LEN1 - 1) / NOTE_LEN1);
    localparam logic [MUL_B_W-1:0] RECIP_NOTE2 =
        MUL_B_W'((2**DIV_SHIFT + NOTE_LEN2 - 1) / NOTE_LEN2);

    localparam logic [7:0] CRAWL_HI  = 8'd200;
    localparam logic [7:0] CRAWL_LO  = 8'd30;
    localparam int         CRAWL_ON0_END   = 4;
    localparam int         CRAWL_ON1_START = 8;
    localparam int         CRAWL_ON1_END   = 12;

    localparam int         LOSS_FRAMES = 10;
    localparam int         LOSS_STEP   = 4;
    localparam logic [7:0] LOSS_GREEN  = 8'd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_MUL,
        ST_MOD_SUB,
        ST_MOD_FIX,
        ST_OPND_MUL,
        ST_RECIP_MUL,
        ST_QUOT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_MOD,
        MUL_OPND,
        MUL_RECIP
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic     rem_sub;
        logic     rem_fix;
        logic     quo_load;
        logic     round;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic item_off;
        logic mode_idle;
        logic out_free;
    } t_status;

    // ramp position (0..38) scaled to 0..255
    function automatic logic [7:0] tri_lookup(input logic [5:0] up);
        logic [7:0] v;
        case (up)
            6'd0:  v = 8'd0;    6'd1:  v = 8'd6;    6'd2:  v = 8'd13;   6'd3:  v = 8'd20;
            6'd4:  v = 8'd26;   6'd5:  v = 8'd33;   6'd6:  v = 8'd40;   6'd7:  v = 8'd46;
            6'd8:  v = 8'd53;   6'd9:  v = 8'd60;   6'd10: v = 8'd67;   6'd11: v = 8'd73;
            6'd12: v = 8'd80;   6'd13: v = 8'd87;   6'd14: v = 8'd93;   6'd15: v = 8'd100;
            6'd16: v = 8'd107;  6'd17: v = 8'd114;  6'd18: v = 8'd120;  6'd19: v = 8'd127;
            6'd20: v = 8'd134;  6'd21: v = 8'd140;  6'd22: v = 8'd147;  6'd23: v = 8'd154;
            6'd24: v = 8'd161;  6'd25: v = 8'd167;  6'd26: v = 8'd174;  6'd27: v = 8'd181;
            6'd28: v = 8'd187;  6'd29: v = 8'd194;  6'd30: v = 8'd201;  6'd31: v = 8'd208;
            6'd32: v = 8'd214;  6'd33: v = 8'd221;  6'd34: v = 8'd228;  6'd35: v = 8'd234;
            6'd36: v = 8'd241;  6'd37: v = 8'd248;  6'd38: v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic t_rgb jackpot_rgb(input logic [2:0] idx);
        t_rgb c;
        case (idx)
            3'd0:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            3'd1:    c = '{red: 8'd255, green: 8'd200, blue: 8'd0};
            3'd2:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            3'd3:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
            3'd4:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            3'd5:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
            default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

endpackage

@@ rtl/rleg_ctrl.sv @@
// Sequencer: steps one tick word through the shared multiplier of the datapath.
module rleg_ctrl
    import rleg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_round, n_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_round = r_round;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MOD_MUL;
                    n_round = 1'b0;
                end
            end
            ST_MOD_MUL:   n_state = i_status.item_off ? ST_EMIT : ST_MOD_SUB;
            ST_MOD_SUB:   n_state = ST_MOD_FIX;
            ST_MOD_FIX:   n_state = ST_OPND_MUL;
            ST_OPND_MUL:  n_state = ST_RECIP_MUL;
            ST_RECIP_MUL: n_state = ST_QUOT;
            ST_QUOT: begin
                // idle breathing needs a second scale pass (span times breath)
                if (i_status.mode_idle && !r_round) begin
                    n_state = ST_OPND_MUL;
                    n_round = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_NONE;
        o_cmd.round    = r_round;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MOD_MUL:   o_cmd.mul_sel  = MUL_MOD;
            ST_MOD_SUB:   o_cmd.rem_sub  = 1'b1;
            ST_MOD_FIX:   o_cmd.rem_fix  = 1'b1;
            ST_OPND_MUL:  o_cmd.mul_sel  = MUL_OPND;
            ST_RECIP_MUL: o_cmd.mul_sel  = MUL_RECIP;
            ST_QUOT:      o_cmd.quo_load = 1'b1;
            ST_EMIT:      o_cmd.emit     = i_status.out_free;
            default:      o_cmd          = '0;
        endcase
    end

    a_one_per_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an accepted word");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("emit issued while output register was blocked");

    a_round_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_round && r_state != ST_IDLE) |-> i_status.mode_idle)
        else $error("second scale pass taken outside idle mode");

endmodule

@@ rtl/rleg_dpath.sv @@
// Datapath: config, effect state, shared multiplier, color select and output register.
module rleg_dpath
    import rleg_pkg::*;
#(
    parameter int PULSE_FRAMES = PULSE_FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_op,
    input  logic [MODE_W-1:0]     i_in_mode,
    input  logic [FRAME_W-1:0]    i_in_frame,
    input  logic [LVL_W-1:0]      i_in_pulse,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_rgb                  o_out_rgb,
    output logic                  o_out_is_off
);

    localparam logic [MUL_B_W-1:0] SPIN_RECIP =
        MUL_B_W'((2**DIV_SHIFT + PULSE_FRAMES - 1) / PULSE_FRAMES);
    localparam logic [PFL_W-1:0]   PFL_LOAD   = PFL_W'(PULSE_FRAMES);

    // config
    logic [7:0]  r_breath_lo, r_breath_hi, r_spin_floor;
    logic [15:0] r_win_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_breath_lo  <= BREATH_LO_RST;
            r_breath_hi  <= BREATH_HI_RST;
            r_spin_floor <= SPIN_FLOOR_RST;
            r_win_hold   <= WIN_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BREATH_LO:  r_breath_lo  <= i_cfg_data[7:0];
                CFG_BREATH_HI:  r_breath_hi  <= i_cfg_data[7:0];
                CFG_SPIN_FLOOR: r_spin_floor <= i_cfg_data[7:0];
                CFG_WIN_HOLD:   r_win_hold   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latched word
    logic                 r_op;
    logic [MODE_W-1:0]    r_mode;
    logic [FRAME_W-1:0]   r_frame;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_op;
            r_mode  <= i_in_mode;
            r_frame <= i_in_frame;
        end
    end

    // pulse tracking, updated at accept of a tick word
    logic [MODE_W-1:0] r_prev_mode;
    logic [PFL_W-1:0]  r_pfl, n_pfl, pfl_keep;
    logic [7:0]        r_peak, n_peak, peak_keep;

    always_comb begin
        pfl_keep  = (i_in_mode != r_prev_mode) ? '0 : r_pfl;
        peak_keep = (i_in_mode != r_prev_mode) ? '0 : r_peak;
        if (i_in_pulse != '0) begin
            n_pfl  = PFL_LOAD;
            n_peak = i_in_pulse;
        end else begin
            n_pfl  = (pfl_keep != '0) ? pfl_keep - 1'b1 : '0;
            n_peak = peak_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mode <= MODE_IDLE;
            r_pfl       <= '0;
            r_peak      <= '0;
        end else if (i_cmd.load && !i_in_op) begin
            r_prev_mode <= i_in_mode;
            r_pfl       <= n_pfl;
            r_peak      <= n_peak;
        end
    end

    // frame reduction: breath phase, crawl phase, jackpot step
    logic [FRAME_W-1:0] mod_x;
    logic [MOD_R_W-1:0] mod_recip;
    logic [6:0]         mod_div;

    always_comb begin
        mod_x     = r_frame;
        mod_recip = BREATH_RECIP;
        mod_div   = 7'(BREATH_PERIOD);
        case (r_mode)
            MODE_CRAWL: begin
                mod_recip = CRAWL_RECIP;
                mod_div   = 7'(CRAWL_PERIOD);
            end
            MODE_JACKPOT: begin
                mod_x     = {2'b00, r_frame[FRAME_W-1:2]};
                mod_recip = JACKPOT_RECIP;
                mod_div   = 7'(JACKPOT_STEPS);
            end
            default: ;
        endcase
    end

    // win phases
    logic               win_hold, win_rest;
    logic [FRAME_W-1:0] win_t;
    logic [2:0]         win_off;
    logic [7:0]         win_peak;
    logic [MUL_B_W-1:0] win_recip;

    always_comb begin
        win_hold  = r_frame < r_win_hold;
        win_t     = r_frame - r_win_hold;
        win_rest  = 1'b0;
        win_off   = win_t[2:0];
        win_peak  = NOTE_PEAK0;
        win_recip = RECIP_NOTE0;
        if (win_t < FRAME_W'(NOTE_END0)) begin
            win_off = win_t[2:0];
        end else if (win_t < FRAME_W'(NOTE_END1)) begin
            win_off   = 3'(win_t - FRAME_W'(NOTE_END0));
            win_peak  = NOTE_PEAK1;
            win_recip = RECIP_NOTE1;
        end else if (win_t < FRAME_W'(NOTE_END2)) begin
            win_off   = 3'(win_t - FRAME_W'(NOTE_END1));
            win_peak  = NOTE_PEAK2;
            win_recip = RECIP_NOTE2;
        end else begin
            win_rest = 1'b1;
        end
    end

    // loss fade level
    logic [5:0] loss_lvl;
    assign loss_lvl = (r_frame < FRAME_W'(LOSS_FRAMES)) ?
        6'((6'(LOSS_FRAMES) - 6'(r_frame[3:0])) * 6'(LOSS_STEP)) : '0;

    // scale operands
    logic [7:0]  r_rem, r_quo;
    logic [5:0]  breath_up;
    logic [7:0]  tri_v, span, spin_peak;
    logic [7:0]  opnd_a, opnd_b;
    logic [MUL_B_W-1:0] div_recip;

    always_comb begin
        breath_up = (r_rem < 8'(BREATH_HALF)) ? r_rem[5:0] : 6'(8'(BREATH_PERIOD) - r_rem);
        tri_v     = tri_lookup(breath_up);
        span      = (r_breath_hi > r_breath_lo) ? r_breath_hi - r_breath_lo : '0;
        spin_peak = (r_peak > r_spin_floor) ? r_peak : r_spin_floor;
        case (r_mode)
            MODE_IDLE: begin
                opnd_a    = i_cmd.round ? span  : tri_v;
                opnd_b    = i_cmd.round ? r_quo : tri_v;
                div_recip = RECIP_255;
            end
            MODE_SPIN: begin
                opnd_a    = spin_peak - r_spin_floor;
                opnd_b    = 8'(r_pfl);
                div_recip = SPIN_RECIP;
            end
            MODE_WIN: begin
                opnd_a    = (win_hold || win_rest) ? '0 : win_peak - WIN_REST;
                opnd_b    = 8'(win_off);
                div_recip = win_recip;
            end
            default: begin
                opnd_a    = 8'(loss_lvl);
                opnd_b    = LOSS_GREEN;
                div_recip = RECIP_255;
            end
        endcase
    end

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  r_prod;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_MOD: begin
                mul_a = mod_x;
                mul_b = MUL_B_W'(mod_recip);
            end
            MUL_OPND: begin
                mul_a = MUL_A_W'(opnd_a);
                mul_b = MUL_B_W'(opnd_b);
            end
            MUL_RECIP: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = div_recip;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    // remainder: the reciprocal quotient is low by at most one
    logic [MOD_Q_W-1:0] mod_q;
    logic [20:0]        rem_wide;

    assign mod_q    = r_prod[MOD_SHIFT +: MOD_Q_W];
    assign rem_wide = 21'(mod_x) - 21'(mod_q) * 21'(mod_div);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rem_sub) begin
            r_rem <= rem_wide[7:0];
        end else if (i_cmd.rem_fix && (r_rem >= 8'(mod_div))) begin
            r_rem <= r_rem - 8'(mod_div);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.quo_load) begin
            r_quo <= r_prod[DIV_SHIFT +: 8];
        end
    end

    // color select
    t_rgb       color;
    logic [7:0] lvl;
    logic [9:0] lvl3;
    logic       crawl_on;

    always_comb begin
        lvl      = '0;
        lvl3     = '0;
        crawl_on = (r_rem < 8'(CRAWL_ON0_END)) ||
                   ((r_rem >= 8'(CRAWL_ON1_START)) && (r_rem < 8'(CRAWL_ON1_END)));
        color    = '0;
        case (r_mode)
            MODE_IDLE: begin
                lvl         = r_breath_lo + r_quo;
                color.red   = lvl;
                color.green = lvl >> 1;
            end
            MODE_SPIN: begin
                lvl         = r_spin_floor + r_quo;
                lvl3        = 10'(lvl) * 10'd3;
                color.red   = lvl >> 1;
                color.green = lvl3[9:2];
                color.blue  = lvl;
            end
            MODE_CRAWL: begin
                lvl         = crawl_on ? CRAWL_HI : CRAWL_LO;
                color.red   = lvl;
                color.green = lvl >> 3;
            end
            MODE_WIN: begin
                color.green = win_hold ? WIN_FULL : (win_rest ? WIN_REST : win_peak - r_quo);
            end
            MODE_JACKPOT: color = jackpot_rgb(r_rem[2:0]);
            default: begin
                color.red   = 8'(loss_lvl);
                color.green = r_quo;
            end
        endcase
    end

    // last sent color and output register
    t_rgb r_sent;
    logic r_sent_valid;
    logic differs, produce;

    assign differs = !r_sent_valid || (color != r_sent);
    assign produce = r_op || differs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent       <= '0;
            r_sent_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            if (r_op) begin
                r_sent_valid <= 1'b0;
            end else if (differs) begin
                r_sent       <= color;
                r_sent_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit && produce) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && produce) begin
            o_out_rgb    <= r_op ? '0 : color;
            o_out_is_off <= r_op;
        end
    end

    assign o_status.item_off  = r_op;
    assign o_status.mode_idle = (r_mode == MODE_IDLE);
    assign o_status.out_free  = !o_out_valid || i_out_ready;

    a_pfl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pfl <= PFL_LOAD)
        else $error("pulse frame count above reload value");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rem_fix |=> (r_rem < 8'(mod_div)))
        else $error("frame reduction left remainder out of range");

    a_mode_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !i_in_op && (i_in_mode != r_prev_mode) && (i_in_pulse == '0))
        |=> (r_pfl == '0))
        else $error("mode change did not clear the pulse");

    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_is_off) |-> (o_out_rgb == '0))
        else $error("off word carries a color");

endmodule

@@ rtl/rgb_led_effect_generator.sv @@
// Top level of the RGB LED effect generator: sequencer plus datapath.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: frame[15:0] pulse_strength[23:16]
//                                                tuser: op[0] mode[3:1]
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: red[7:0] green[15:8] blue[23:16]
//                                                tuser: is_off[0]
//  cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data[15:0]
//
// A tick word runs the frame reduction (multiply, subtract, fix), the scale
// (operand and reciprocal multiply, quotient) and emit, with two scale passes
// in idle mode; an off word skips to emit. One shared multiplier serves both.
// Results sit in an output register, so the next word is taken while a
// color waits; the sequencer only stalls when that register is still full.
// Reset is synchronous, active low, and restores the config defaults.
module rgb_led_effect_generator
    import rleg_pkg::*;
#(
    parameter int PULSE_FRAMES = PULSE_FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // tick words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // frame[15:0], pulse_strength[23:16]
    input  logic [3:0]            s_axis_tuser,   // op[0], mode[3:1]
    // color words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic                  m_axis_tuser    // is_off[0]
);

    t_cmd    cmd;
    t_status status;
    t_rgb    out_rgb;

    rleg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rleg_dpath #(
        .PULSE_FRAMES (PULSE_FRAMES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_op      (s_axis_tuser[0]),
        .i_in_mode    (s_axis_tuser[3:1]),
        .i_in_frame   (s_axis_tdata[15:0]),
        .i_in_pulse   (s_axis_tdata[23:16]),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_rgb    (out_rgb),
        .o_out_is_off (m_axis_tuser)
    );

    // red in the low byte
    assign m_axis_tdata = {out_rgb.blue, out_rgb.green, out_rgb.red};

endmodule
